@@ rtl/core/gga_pkg.sv @@
// ----------------------------------------------------------------------------
// gga_pkg
// types and constants shared by the glyph address parser files
// ----------------------------------------------------------------------------
package gga_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PAGE_W = 4;
   localparam int unsigned ADDR_W = 18;
   localparam int unsigned CELL_W = 13;
   localparam int unsigned ROW_W  = 7;

   // byte classes
   localparam logic [BYTE_W-1:0] HANZI_LEAD_LO = 8'hB0;
   localparam logic [BYTE_W-1:0] HANZI_LEAD_HI = 8'hF7;
   localparam logic [BYTE_W-1:0] SYM_LEAD_LO   = 8'hA1;
   localparam logic [BYTE_W-1:0] SYM_LEAD_HI   = 8'hA3;
   localparam logic [BYTE_W-1:0] TRAIL_LO      = 8'hA1;
   localparam logic [BYTE_W-1:0] ASCII_LO      = 8'h20;
   localparam logic [BYTE_W-1:0] ASCII_HI      = 8'h7E;
   localparam logic [BYTE_W-1:0] END_OF_TEXT   = 8'h00;

   // font layout
   localparam logic [CELL_W-1:0] ROW_CELLS    = 13'd94;
   localparam logic [CELL_W-1:0] HANZI_OFFSET = 13'd846;
   localparam int unsigned       WIDE_SHIFT   = 5;
   localparam int unsigned       NARROW_SHIFT = 4;
   localparam logic [ADDR_W-1:0] ASCII_BASE   = 18'h3CF80;

   // column advance per glyph
   localparam logic [BYTE_W-1:0] WIDE_STEP   = 8'd16;
   localparam logic [BYTE_W-1:0] NARROW_STEP = 8'd8;

   // glyph kind codes
   localparam logic KIND_WIDE   = 1'b0;
   localparam logic KIND_NARROW = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              start_of_text;
      logic [PAGE_W-1:0] start_page;
      logic [BYTE_W-1:0] start_column;
      logic              normal_video;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] font_address;
      logic              glyph_kind;
      logic [PAGE_W-1:0] glyph_page;
      logic [BYTE_W-1:0] glyph_column;
      logic              glyph_normal_video;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] wide_address;
      logic [ADDR_W-1:0] narrow_address;
   } glyph_addr_type;

endpackage

@@ rtl/core/gga_if.sv @@
// ----------------------------------------------------------------------------
// gga channel interfaces
// valid/ready channels for text bytes in and glyph requests out
// ----------------------------------------------------------------------------
interface gga_req_if import gga_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              start_of_text;
   logic [PAGE_W-1:0] start_page;
   logic [BYTE_W-1:0] start_column;
   logic              normal_video;

   modport source (
      output valid, text_byte, start_of_text, start_page, start_column, normal_video,
      input  ready
   );
   modport sink (
      input  valid, text_byte, start_of_text, start_page, start_column, normal_video,
      output ready
   );
endinterface

interface gga_rsp_if import gga_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] font_address;
   logic              glyph_kind;
   logic [PAGE_W-1:0] glyph_page;
   logic [BYTE_W-1:0] glyph_column;
   logic              glyph_normal_video;

   modport source (
      output valid, font_address, glyph_kind, glyph_page, glyph_column,
             glyph_normal_video,
      input  ready
   );
   modport sink (
      input  valid, font_address, glyph_kind, glyph_page, glyph_column,
             glyph_normal_video,
      output ready
   );
endinterface

@@ rtl/core/gb2312_glyph_address_parser_top.sv @@
// ----------------------------------------------------------------------------
// gb2312_glyph_address_parser_top
// turns a gb2312/ascii byte stream into font rom glyph requests
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            contents
//   req_bus   in         valid/ready          text byte, start flag, page,
//                                              column, video mode
//   rsp_bus   out        valid/ready          font address, kind, page,
//                                              column, video mode
//
// one request per cycle is taken at full rate, with or without a result, while the result side does not stall
// a result passes from the request register through the parse step into the
// result register, and is valid once it sits there
// the rate is set by the single parse step between the request register
// and the result register; a lead byte only updates state and gives no result
// reset (synchronous, active high) clears both valid flags and the text state
// a stalled result holds the result register; the request register still
// takes one more request, then ready drops until the result is taken
// ----------------------------------------------------------------------------
module gb2312_glyph_address_parser_top import gga_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gga_req_if.sink   req_bus,
   gga_rsp_if.source rsp_bus
);

   // request register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         advance;
   logic         req_take;
   logic         emit;
   rsp_item_type glyph;

   // parse step runs when a request is held and the result slot frees up
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.text_byte     = req_bus.text_byte;
      in_item_in.start_of_text = req_bus.start_of_text;
      in_item_in.start_page    = req_bus.start_page;
      in_item_in.start_column  = req_bus.start_column;
      in_item_in.normal_video  = req_bus.normal_video;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // result slot: refilled on a step, otherwise drained by the sink
      if (advance) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_bus.ready;
      end
      out_item_in = glyph;
   end

   gga_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .emit  (emit),
      .glyph (glyph)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (advance && emit) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.font_address       = out_item_ff.font_address;
   assign rsp_bus.glyph_kind         = out_item_ff.glyph_kind;
   assign rsp_bus.glyph_page         = out_item_ff.glyph_page;
   assign rsp_bus.glyph_column       = out_item_ff.glyph_column;
   assign rsp_bus.glyph_normal_video = out_item_ff.glyph_normal_video;

   // an empty request register never pushes back
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("request stalled with empty request register");

   // reset leaves no result pending
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result valid right after reset");

   // a waiting result blocks the parse step
   a_no_step_over_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !advance)
      else $error("parse step overwrote a waiting result");

endmodule

@@ rtl/core/gga_addr_calc.sv @@
// ----------------------------------------------------------------------------
// gga_addr_calc
// font rom byte addresses for a double-byte pair and for an ascii byte
// ----------------------------------------------------------------------------
module gga_addr_calc import gga_pkg::*; (
   input  logic [BYTE_W-1:0] lead_byte,
   input  logic [BYTE_W-1:0] cur_byte,
   output glyph_addr_type    glyph_addr
);

   logic              lead_hanzi;
   logic [ROW_W-1:0]  row;
   logic [ROW_W-1:0]  trail_cell;
   logic [CELL_W-1:0] cell_index;

   always_comb begin
      lead_hanzi = (lead_byte >= HANZI_LEAD_LO);
      row        = lead_hanzi ? ROW_W'(lead_byte - HANZI_LEAD_LO)
                              : ROW_W'(lead_byte - SYM_LEAD_LO);
      trail_cell = ROW_W'(cur_byte - TRAIL_LO);
      // row * 94 + column within row, hanzi rows sit after the symbol area
      cell_index = CELL_W'(row) * ROW_CELLS + CELL_W'(trail_cell)
                 + (lead_hanzi ? HANZI_OFFSET : CELL_W'(0));
      glyph_addr.wide_address   = ADDR_W'(cell_index) << WIDE_SHIFT;
      glyph_addr.narrow_address = (ADDR_W'(BYTE_W'(cur_byte - ASCII_LO)) << NARROW_SHIFT)
                                + ASCII_BASE;
   end

endmodule

@@ rtl/core/gga_parser.sv @@
// ----------------------------------------------------------------------------
// gga_parser
// text state and glyph decision for one byte per step
// ----------------------------------------------------------------------------
module gga_parser import gga_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output logic         emit,
   output rsp_item_type glyph
);

   logic [BYTE_W-1:0] held_lead_ff, held_lead_in;
   logic              lead_pending_ff, lead_pending_in;
   logic              text_active_ff, text_active_in;
   logic [BYTE_W-1:0] column_ff, column_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              mode_ff, mode_in;

   glyph_addr_type    glyph_addr;

   gga_addr_calc u_addr_calc (
      .lead_byte  (held_lead_ff),
      .cur_byte   (item.text_byte),
      .glyph_addr (glyph_addr)
   );

   always_comb begin
      logic [BYTE_W-1:0] b;
      logic              active;
      logic              pending;
      logic [BYTE_W-1:0] col;
      logic [PAGE_W-1:0] page;
      logic              mode;
      logic              is_lead;
      logic              is_ascii;
      logic              judge_ascii;

      b        = item.text_byte;
      active   = text_active_ff;
      pending  = lead_pending_ff;
      col      = column_ff;
      page     = page_ff;
      mode     = mode_ff;
      is_lead  = ((b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI))
              || ((b >= SYM_LEAD_LO) && (b <= SYM_LEAD_HI));
      is_ascii = (b >= ASCII_LO) && (b <= ASCII_HI);
      judge_ascii = 1'b0;

      held_lead_in    = held_lead_ff;
      lead_pending_in = lead_pending_ff;
      text_active_in  = text_active_ff;
      column_in       = column_ff;
      page_in         = page_ff;
      mode_in         = mode_ff;
      emit            = 1'b0;

      if (item.start_of_text) begin
         active       = 1'b1;
         pending      = 1'b0;
         held_lead_in = '0;
         col          = item.start_column;
         page         = item.start_page;
         mode         = item.normal_video;
      end

      glyph.font_address       = glyph_addr.narrow_address;
      glyph.glyph_kind         = KIND_NARROW;
      glyph.glyph_page         = page;
      glyph.glyph_column       = col;
      glyph.glyph_normal_video = mode;

      text_active_in  = active;
      lead_pending_in = pending;
      column_in       = col;
      page_in         = page;
      mode_in         = mode;

      if (active) begin
         if (b == END_OF_TEXT) begin
            text_active_in  = 1'b0;
            lead_pending_in = 1'b0;
         end else if (pending) begin
            lead_pending_in = 1'b0;
            if (b >= TRAIL_LO) begin
               emit             = 1'b1;
               glyph.font_address = glyph_addr.wide_address;
               glyph.glyph_kind = KIND_WIDE;
               column_in        = col + WIDE_STEP;
            end else begin
               // lead dropped, this byte is judged on its own
               judge_ascii = 1'b1;
            end
         end else if (is_lead) begin
            held_lead_in    = b;
            lead_pending_in = 1'b1;
         end else begin
            judge_ascii = 1'b1;
         end
      end

      if (judge_ascii && is_ascii) begin
         emit      = 1'b1;
         column_in = col + NARROW_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff    <= '0;
         lead_pending_ff <= 1'b0;
         text_active_ff  <= 1'b0;
         column_ff       <= '0;
         page_ff         <= PAGE_W'(1);
         mode_ff         <= 1'b1;
      end else if (step) begin
         held_lead_ff    <= held_lead_in;
         lead_pending_ff <= lead_pending_in;
         text_active_ff  <= text_active_in;
         column_ff       <= column_in;
         page_ff         <= page_in;
         mode_ff         <= mode_in;
      end
   end

   // a pending lead always holds a valid lead byte
   a_held_is_lead: assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> (((held_lead_ff >= HANZI_LEAD_LO) && (held_lead_ff <= HANZI_LEAD_HI))
                        || ((held_lead_ff >= SYM_LEAD_LO) && (held_lead_ff <= SYM_LEAD_HI))))
      else $error("pending lead byte is not a lead code");

   // double-byte addresses stay below the ascii area
   a_wide_below_ascii: assert property (@(posedge clock) disable iff (reset)
      (emit && (glyph.glyph_kind == KIND_WIDE)) |-> (glyph.font_address < ASCII_BASE))
      else $error("double-byte glyph address runs into ascii area");

   // no pending lead outside an active text
   a_pending_needs_text: assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> text_active_ff)
      else $error("lead pending while no text active");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks the gb2312/ascii glyph address parser against a behavioral parser
// running alongside it: a short table of hand-picked bytes first, then random
// texts under several patterns of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;
   import gga_pkg::*;

   localparam int unsigned PHASE_REQUESTS = 250;     // random requests per phase
   localparam int unsigned HOLD_CYCLES    = 300;     // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES   = 8;       // extra wait for stray glyphs after the drain
   localparam int unsigned TIMEOUT_CYCLES = 200000;

   // how a stimulus row is checked
   typedef enum logic [1:0] {
      FROM_PARSER,   // expectation comes from the behavioral parser
      TYPED_NONE,    // no glyph may come out of this request
      TYPED_GLYPH    // the glyph is written out in the table
   } row_check_type;

   typedef struct {
      req_item_type  rq;
      row_check_type mode;
      rsp_item_type  glyph;
   } text_row_type;

   // idling patterns, walked in this order
   typedef enum logic [2:0] {
      PH_FULL_RATE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } phase_type;

   logic clock;
   logic reset;

   gga_req_if req_bus ();
   gga_rsp_if rsp_bus ();

   gb2312_glyph_address_parser_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // behavioral parser state, at its reset values
   logic [BYTE_W-1:0] held_lead  = '0;
   bit                lead_held  = 1'b0;
   bit                in_text    = 1'b0;
   logic [BYTE_W-1:0] cur_column = '0;
   logic [PAGE_W-1:0] cur_page   = 4'd1;
   logic              cur_video  = 1'b1;

   text_row_type stimulus_q[$];
   rsp_item_type glyph_expect_q[$];

   phase_type   phase          = PH_FULL_RATE;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_off       = 1'b0;
   bit          start_due      = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned glyph_count    = 0;

   // ------------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // behavioral parser: one request in, zero or one glyph out
   // ------------------------------------------------------------------------
   function automatic bit parse_glyph(input req_item_type rq, output rsp_item_type glyph);
      logic [BYTE_W-1:0] b;
      int unsigned       lead;
      int unsigned       trail;
      int unsigned       cell_index;
      int unsigned       addr;
      b     = rq.text_byte;
      lead  = 32'(held_lead);
      trail = 32'(b);
      glyph = '0;
      // a start loads page, column and mode and drops any held lead
      if (rq.start_of_text) begin
         in_text    = 1'b1;
         lead_held  = 1'b0;
         held_lead  = '0;
         cur_page   = rq.start_page;
         cur_column = rq.start_column;
         cur_video  = rq.normal_video;
      end
      if (!in_text) return 1'b0;
      // terminator ends the text, silently dropping a held lead
      if (b == END_OF_TEXT) begin
         in_text   = 1'b0;
         lead_held = 1'b0;
         return 1'b0;
      end
      if (lead_held) begin
         lead_held = 1'b0;
         if (b >= TRAIL_LO) begin
            if (held_lead >= HANZI_LEAD_LO)
               cell_index = (lead - HANZI_LEAD_LO) * ROW_CELLS + (trail - TRAIL_LO)
                          + HANZI_OFFSET;
            else
               cell_index = (lead - SYM_LEAD_LO) * ROW_CELLS + (trail - TRAIL_LO);
            addr = cell_index << WIDE_SHIFT;
            glyph.font_address       = addr[ADDR_W-1:0];
            glyph.glyph_kind         = KIND_WIDE;
            glyph.glyph_page         = cur_page;
            glyph.glyph_column       = cur_column;
            glyph.glyph_normal_video = cur_video;
            cur_column = cur_column + WIDE_STEP;
            return 1'b1;
         end
         // low byte after a lead: lead is lost, byte judged on its own below
      end else if ((b >= HANZI_LEAD_LO && b <= HANZI_LEAD_HI) ||
                   (b >= SYM_LEAD_LO && b <= SYM_LEAD_HI)) begin
         held_lead = b;
         lead_held = 1'b1;
         return 1'b0;
      end
      if (b >= ASCII_LO && b <= ASCII_HI) begin
         addr = ((trail - ASCII_LO) << NARROW_SHIFT) + ASCII_BASE;
         glyph.font_address       = addr[ADDR_W-1:0];
         glyph.glyph_kind         = KIND_NARROW;
         glyph.glyph_page         = cur_page;
         glyph.glyph_column       = cur_column;
         glyph.glyph_normal_video = cur_video;
         cur_column = cur_column + NARROW_STEP;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   // one directed table row; typed glyph fields matter only for TYPED_GLYPH
   task automatic add_row(input logic [BYTE_W-1:0] text_byte, input logic sot,
                          input logic [PAGE_W-1:0] page, input logic [BYTE_W-1:0] column,
                          input logic video, input row_check_type mode,
                          input logic [ADDR_W-1:0] addr, input logic kind,
                          input logic [PAGE_W-1:0] gpage, input logic [BYTE_W-1:0] gcolumn,
                          input logic gvideo);
      text_row_type r;
      r.rq.text_byte                = text_byte;
      r.rq.start_of_text            = sot;
      r.rq.start_page               = page;
      r.rq.start_column             = column;
      r.rq.normal_video             = video;
      r.mode                        = mode;
      r.glyph.font_address          = addr;
      r.glyph.glyph_kind            = kind;
      r.glyph.glyph_page            = gpage;
      r.glyph.glyph_column          = gcolumn;
      r.glyph.glyph_normal_video    = gvideo;
      stimulus_q.push_back(r);
   endtask

   // random text byte; carries the start of a new text when one is due
   task automatic push_text_byte(input logic [BYTE_W-1:0] b);
      text_row_type r;
      r.rq.text_byte     = b;
      r.rq.start_of_text = start_due;
      // mostly legal pages, now and then any 4-bit value
      r.rq.start_page    = PAGE_W'(($urandom_range(9, 0) == 0) ? $urandom_range(15, 0)
                                                               : $urandom_range(8, 1));
      r.rq.start_column  = BYTE_W'($urandom_range(255, 0));
      r.rq.normal_video  = 1'($urandom_range(1, 0));
      r.mode             = FROM_PARSER;
      r.glyph            = '0;
      start_due          = 1'b0;
      stimulus_q.push_back(r);
   endtask

   function automatic logic [BYTE_W-1:0] random_lead();
      if ($urandom_range(4, 0) == 0) return BYTE_W'($urandom_range(SYM_LEAD_HI, SYM_LEAD_LO));
      return BYTE_W'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO));
   endfunction

   // one text: a start, a run of glyphs with some noise, then usually an ending
   task automatic compose_text();
      int unsigned pick;
      // stray byte between texts, usually with no text active
      if ($urandom_range(9, 0) == 0) push_text_byte(BYTE_W'($urandom_range(255, 0)));
      start_due = 1'b1;
      repeat ($urandom_range(24, 1)) begin
         pick = $urandom_range(99, 0);
         if (pick < 35) begin
            push_text_byte(BYTE_W'($urandom_range(ASCII_HI, ASCII_LO)));
         end else if (pick < 62) begin
            push_text_byte(BYTE_W'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO)));
            push_text_byte(BYTE_W'($urandom_range(8'hFF, TRAIL_LO)));
         end else if (pick < 74) begin
            push_text_byte(BYTE_W'($urandom_range(SYM_LEAD_HI, SYM_LEAD_LO)));
            push_text_byte(BYTE_W'($urandom_range(8'hFF, TRAIL_LO)));
         end else if (pick < 82) begin
            // broken pair: lead followed by a nonzero low byte
            push_text_byte(random_lead());
            push_text_byte(BYTE_W'($urandom_range(TRAIL_LO - 1, 1)));
         end else if (pick < 92) begin
            push_text_byte(BYTE_W'($urandom_range(255, 1)));
         end else if (pick < 96) begin
            // restart in the middle of the text
            start_due = 1'b1;
            push_text_byte(BYTE_W'($urandom_range(255, 0)));
         end else begin
            // early terminator, a fresh text follows at once
            push_text_byte(END_OF_TEXT);
            start_due = 1'b1;
         end
      end
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
         push_text_byte(END_OF_TEXT);
      end else if (pick < 80) begin
         push_text_byte(random_lead());
         push_text_byte(END_OF_TEXT);
      end else if (pick < 88) begin
         // dangling lead, usually dropped by the next start
         push_text_byte(random_lead());
      end
      start_due = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // request driver: called at a falling edge, returns at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_request(input text_row_type r);
      rsp_item_type glyph;
      bit           hit;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.text_byte     <= r.rq.text_byte;
      req_bus.start_of_text <= r.rq.start_of_text;
      req_bus.start_page    <= r.rq.start_page;
      req_bus.start_column  <= r.rq.start_column;
      req_bus.normal_video  <= r.rq.normal_video;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // request accepted at this edge: advance the parser
      hit = parse_glyph(r.rq, glyph);
      if (r.mode == TYPED_NONE) begin
         hit = 1'b0;
      end else if (r.mode == TYPED_GLYPH) begin
         hit   = 1'b1;
         glyph = r.glyph;
      end
      if (hit) glyph_expect_q.push_back(glyph);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: random stalls, plus the long hold-off in its own process
   // ------------------------------------------------------------------------
   initial begin : result_sink
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !hold_off && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // hold the result side off while the sender keeps offering requests,
   // so the block fills and drops req ready
   initial begin : result_hold
      wait (phase == PH_BACKPRESSURE);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t glyph %0d %s: got %h, want %h", $time, glyph_count, what, got, want);
   endtask

   always @(posedge clock) begin : glyph_check
      rsp_item_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (glyph_expect_q.size() == 0) begin
            flag_mismatch("glyph with no request behind it", 32'(rsp_bus.font_address), '0);
         end else begin
            want = glyph_expect_q.pop_front();
            if (rsp_bus.font_address !== want.font_address)
               flag_mismatch("font_address", 32'(rsp_bus.font_address),
                             32'(want.font_address));
            if (rsp_bus.glyph_kind !== want.glyph_kind)
               flag_mismatch("glyph_kind", 32'(rsp_bus.glyph_kind), 32'(want.glyph_kind));
            if (rsp_bus.glyph_page !== want.glyph_page)
               flag_mismatch("glyph_page", 32'(rsp_bus.glyph_page), 32'(want.glyph_page));
            if (rsp_bus.glyph_column !== want.glyph_column)
               flag_mismatch("glyph_column", 32'(rsp_bus.glyph_column),
                             32'(want.glyph_column));
            if (rsp_bus.glyph_normal_video !== want.glyph_normal_video)
               flag_mismatch("glyph_normal_video", 32'(rsp_bus.glyph_normal_video),
                             32'(want.glyph_normal_video));
         end
         glyph_count++;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.text_byte     = '0;
      req_bus.start_of_text = 1'b0;
      req_bus.start_page    = '0;
      req_bus.start_column  = '0;
      req_bus.normal_video  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, full rate
      // byte with no text active is ignored
      add_row(8'h41, 1'b0, 4'd3, 8'h07, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      // ascii extremes
      add_row(8'h20, 1'b1, 4'd1, 8'h00, 1'b1, TYPED_GLYPH, 18'h3CF80, KIND_NARROW,
              4'd1, 8'h00, 1'b1);
      add_row(8'h7E, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h3D560, KIND_NARROW,
              4'd1, 8'h08, 1'b1);
      // control byte and del are skipped
      add_row(8'h1F, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h7F, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      // first hanzi cell
      add_row(8'hB0, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'hA1, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h069C0, KIND_WIDE,
              4'd1, 8'h10, 1'b1);
      // last hanzi lead with a 0xff trail
      add_row(8'hF7, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'hFF, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h3B7C0, KIND_WIDE,
              4'd1, 8'h20, 1'b1);
      // first and last symbol rows
      add_row(8'hA1, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'hA1, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h00000, KIND_WIDE,
              4'd1, 8'h30, 1'b1);
      add_row(8'hA3, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'hFE, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h02320, KIND_WIDE,
              4'd1, 8'h40, 1'b1);
      // lead then printable byte: lead lost, byte drawn as ascii
      add_row(8'hC5, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h41, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_GLYPH, 18'h3D190, KIND_NARROW,
              4'd1, 8'h50, 1'b1);
      // lead then non-printable low byte: both gone
      add_row(8'hB5, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h80, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      // lead then terminator
      add_row(8'hD0, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h00, 1'b0, 4'd0, 8'h00, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h41, 1'b0, 4'd2, 8'h11, 1'b1, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      // restart drops a held lead; odd pages pass through; column wraps
      add_row(8'hB0, 1'b1, 4'd15, 8'hFC, 1'b0, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'h30, 1'b1, 4'd0, 8'hF8, 1'b0, TYPED_GLYPH, 18'h3D080, KIND_NARROW,
              4'd0, 8'hF8, 1'b0);
      add_row(8'h7A, 1'b0, 4'd9, 8'h33, 1'b1, TYPED_GLYPH, 18'h3D520, KIND_NARROW,
              4'd0, 8'h00, 1'b0);
      // hanzi across the wrap
      add_row(8'hE0, 1'b1, 4'd8, 8'hF5, 1'b1, FROM_PARSER, '0, KIND_WIDE, '0, '0, 1'b0);
      add_row(8'hC0, 1'b0, 4'd0, 8'h00, 1'b0, FROM_PARSER, '0, KIND_WIDE, '0, '0, 1'b0);
      // start and terminator in one request
      add_row(8'h00, 1'b1, 4'd4, 8'h44, 1'b1, TYPED_NONE, '0, KIND_WIDE, '0, '0, 1'b0);
      while (stimulus_q.size() != 0) send_request(stimulus_q.pop_front());

      // random texts, one batch per idling pattern
      for (int p = PH_FULL_RATE; p <= PH_BACKPRESSURE; p++) begin
         phase = phase_type'(p);
         case (phase)
            PH_FULL_RATE: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            PH_SEND_IDLE: begin
               send_idle_pct = 71; recv_stall_pct = 0;
            end
            PH_RECV_STALL: begin
               send_idle_pct = 0;  recv_stall_pct = 71;
            end
            PH_BOTH_IDLE: begin
               send_idle_pct = 34; recv_stall_pct = 34;
            end
            default: begin
               // sender flat out against the hold-off
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
         endcase
         while (stimulus_q.size() < PHASE_REQUESTS) compose_text();
         while (stimulus_q.size() != 0) send_request(stimulus_q.pop_front());
      end
      req_bus.valid <= 1'b0;

      // drain outstanding glyphs, then give stray ones a chance to show
      while (glyph_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("gb2312_glyph_address_parser_top test passed");
      else
         $display("gb2312_glyph_address_parser_top test failed");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin : run_limit
      #(TIMEOUT_CYCLES * 10);
      $display("gb2312_glyph_address_parser_top test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/gga_pkg.sv
rtl/core/gga_if.sv
rtl/core/gga_addr_calc.sv
rtl/core/gga_parser.sv
rtl/core/gb2312_glyph_address_parser_top.sv
tb/sv/tb.sv
